// File: rtl/core/usbctl_pkg.sv
`timescale 1ns / 1ps

package usbctl_pkg;

    localparam int MAX_PACKET_DEF = 64;

    localparam int LEN_W   = 16;
    localparam int XFER_W  = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        CMD_RESET        = 2'd0,
        CMD_START_DATA   = 2'd1,
        CMD_START_STATUS = 2'd2,
        CMD_COMPLETE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_DATA   = 3'd1,
        ACT_STATUS = 3'd2,
        ACT_STALL  = 3'd3,
        ACT_ERROR  = 3'd4
    } action_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               req_dir_in;
        logic [LEN_W-1:0]   req_length;
        logic [LEN_W-1:0]   avail_len;
        logic               ep_dir_in;
        logic [XFER_W-1:0]  xferred;
        logic               app_ok;
    } in_item_t;

    typedef struct packed {
        action_t            action;
        logic               out_dir_in;
        logic [XFER_W-1:0]  packet_len;
        logic [LEN_W-1:0]   packet_offset;
        logic [LEN_W-1:0]   copy_offset;
    } out_item_t;

endpackage

// File: rtl/core/usb_control_transfer_stager_unit.sv
`timescale 1ns / 1ps
// Endpoint-0 control transfer stager: one result beat for every input beat.
// Registers: input register, then result register; an accepted beat passes
// through both before it leaves, and the result waits further while
// m_axis_tready is low; the transfer state updates as each beat advances.
// Throughput: one beat per cycle unless m_axis_tready stalls the result register.
// Reset: rst_n clears both pipeline valids and the transfer state at once.
module usb_control_transfer_stager_unit #(
    parameter int MAX_PACKET = usbctl_pkg::MAX_PACKET_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] req_dir_in, [16:1] req_length, [32:17] avail_len, [33] ep_dir_in,
    // [40:34] xferred, [41] app_ok, [47:42] zero
    input  logic [usbctl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] out_dir_in, [7:1] packet_len, [23:8] packet_offset,
    // [39:24] copy_offset
    output logic [usbctl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [2:0] action
    output logic [2:0]                          m_axis_tuser
);

    localparam int LW = usbctl_pkg::LEN_W;
    localparam int XW = usbctl_pkg::XFER_W;
    localparam logic [LW-1:0] MaxPkt16 = LW'(MAX_PACKET);
    localparam logic [XW-1:0] MaxPkt7  = XW'(MAX_PACKET);

    // Pipeline registers
    logic                 in_valid_reg;
    usbctl_pkg::in_item_t in_reg;
    logic                 out_valid_reg;
    usbctl_pkg::out_item_t out_reg;
    usbctl_pkg::out_item_t out_next;

    // Transfer state
    logic          dir_in_reg,       dir_in_next;
    logic [LW-1:0] setup_length_reg, setup_length_next;
    logic [LW-1:0] data_length_reg,  data_length_next;
    logic [LW-1:0] total_moved_reg,  total_moved_next;

    logic out_load;
    logic in_load;

    // Advance the input stage into the result register when the result
    // slot is free or is being drained this cycle.
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Unpack the beat into the input register
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg.cmd        <= usbctl_pkg::cmd_t'(s_axis_tuser);
            in_reg.req_dir_in <= s_axis_tdata[0];
            in_reg.req_length <= s_axis_tdata[16:1];
            in_reg.avail_len  <= s_axis_tdata[32:17];
            in_reg.ep_dir_in  <= s_axis_tdata[33];
            in_reg.xferred    <= s_axis_tdata[40:34];
            in_reg.app_ok     <= s_axis_tdata[41];
        end
    end

    // Stage logic: state update and result for the item in the input register
    logic [LW-1:0] start_len;
    logic [LW:0]   sum_wide;
    logic [LW-1:0] total_sat;
    logic [LW-1:0] rem_total;
    logic [LW-1:0] rem_len;
    logic [XW-1:0] pkt_len;
    logic [LW-1:0] coff;
    logic          stage_end;

    always_comb
    begin
        start_len = (in_reg.avail_len < in_reg.req_length) ?
                    in_reg.avail_len : in_reg.req_length;
        sum_wide  = {1'b0, total_moved_reg} + (LW+1)'(in_reg.xferred);
        // Saturate the running total
        total_sat = sum_wide[LW] ? {LW{1'b1}} : sum_wide[LW-1:0];
        coff      = dir_in_reg ? '0 : total_moved_reg;
        stage_end = (setup_length_reg == total_sat) || (in_reg.xferred < MaxPkt7);

        // Total after this item: the updated total on a completion, zero on any other command
        if (in_reg.cmd == usbctl_pkg::CMD_COMPLETE)
        begin
            rem_total = total_sat;
        end
        else
        begin
            rem_total = '0;
        end

        // Remaining length clamps at zero; length of next packet caps at max
        if (in_reg.cmd == usbctl_pkg::CMD_START_DATA)
        begin
            rem_len = start_len;
        end
        else
        begin
            rem_len = (data_length_reg > rem_total) ? data_length_reg - rem_total : '0;
        end
        pkt_len = (rem_len < MaxPkt16) ? rem_len[XW-1:0] : MaxPkt7;
    end

    always_comb
    begin
        dir_in_next       = dir_in_reg;
        setup_length_next = setup_length_reg;
        data_length_next  = data_length_reg;
        total_moved_next  = total_moved_reg;
        out_next          = '0;
        out_next.action   = usbctl_pkg::ACT_NONE;

        case (in_reg.cmd)
            usbctl_pkg::CMD_RESET:
            begin
                dir_in_next       = 1'b0;
                setup_length_next = '0;
                data_length_next  = '0;
                total_moved_next  = '0;
            end
            usbctl_pkg::CMD_START_DATA:
            begin
                dir_in_next       = in_reg.req_dir_in;
                setup_length_next = in_reg.req_length;
                data_length_next  = start_len;
                total_moved_next  = '0;
                if (start_len != '0)
                begin
                    out_next.action     = usbctl_pkg::ACT_DATA;
                    out_next.out_dir_in = in_reg.req_dir_in;
                    out_next.packet_len = pkt_len;
                end
                else
                begin
                    out_next.action     = usbctl_pkg::ACT_STATUS;
                    out_next.out_dir_in = !in_reg.req_dir_in;
                end
            end
            usbctl_pkg::CMD_START_STATUS:
            begin
                dir_in_next         = in_reg.req_dir_in;
                setup_length_next   = in_reg.req_length;
                data_length_next    = '0;
                total_moved_next    = '0;
                out_next.action     = usbctl_pkg::ACT_STATUS;
                out_next.out_dir_in = !in_reg.req_dir_in;
            end
            usbctl_pkg::CMD_COMPLETE:
            begin
                if (in_reg.ep_dir_in != dir_in_reg)
                begin
                    // Status stage done: any payload here is a protocol error
                    out_next.action = (in_reg.xferred == '0) ?
                                      usbctl_pkg::ACT_NONE : usbctl_pkg::ACT_ERROR;
                end
                else
                begin
                    total_moved_next     = total_sat;
                    out_next.copy_offset = coff;
                    if (stage_end)
                    begin
                        if (in_reg.app_ok)
                        begin
                            out_next.action     = usbctl_pkg::ACT_STATUS;
                            out_next.out_dir_in = !dir_in_reg;
                        end
                        else
                        begin
                            out_next.action = usbctl_pkg::ACT_STALL;
                        end
                    end
                    else
                    begin
                        out_next.action        = usbctl_pkg::ACT_DATA;
                        out_next.out_dir_in    = dir_in_reg;
                        out_next.packet_len    = pkt_len;
                        out_next.packet_offset = total_sat;
                    end
                end
            end
            default:
            begin
                out_next.action = usbctl_pkg::ACT_NONE;
            end
        endcase
    end

    // Transfer state advances only as items leave the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_in_reg       <= 1'b0;
            setup_length_reg <= '0;
            data_length_reg  <= '0;
            total_moved_reg  <= '0;
        end
        else if (out_load)
        begin
            dir_in_reg       <= dir_in_next;
            setup_length_reg <= setup_length_next;
            data_length_reg  <= data_length_next;
            total_moved_reg  <= total_moved_next;
        end
    end

    // Result register: hold while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tdata  = {out_reg.copy_offset, out_reg.packet_offset,
                            out_reg.packet_len, out_reg.out_dir_in};

    // A data packet never exceeds the max packet size
    a_pkt_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == usbctl_pkg::ACT_DATA)
        |-> (m_axis_tdata[7:1] <= MaxPkt7))
        else $error("packet_len above max packet size");

    // Only data beats carry a packet length or packet offset
    a_pkt_only_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != usbctl_pkg::ACT_DATA)
        |-> (m_axis_tdata[23:1] == '0))
        else $error("packet fields set on a non-data beat");

    // No direction on none, stall or error beats
    a_dir_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == usbctl_pkg::ACT_NONE ||
                           m_axis_tuser == usbctl_pkg::ACT_STALL ||
                           m_axis_tuser == usbctl_pkg::ACT_ERROR))
        |-> !m_axis_tdata[0])
        else $error("direction set on a beat that queues nothing");

    // A reset command clears the transfer state as it passes
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && in_reg.cmd == usbctl_pkg::CMD_RESET)
        |=> (total_moved_reg == '0 && data_length_reg == '0 &&
             setup_length_reg == '0 && !dir_in_reg))
        else $error("reset command left transfer state behind");

endmodule

// File: test/usb_control_transfer_stager_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the endpoint-0 control transfer stager.
// Every accepted input beat is run through a local model of the transfer
// state; the predicted beat, or a directed row's fixed expectation, is queued
// and compared field by field with the next beat that leaves the block.
module usb_control_transfer_stager_unit_tb;

    localparam int PKT_MAX      = usbctl_pkg::MAX_PACKET_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BEATS  = 20;
    localparam int HOLD_BEATS   = 20;
    localparam int GAP_MAX      = 12;
    localparam int SAT_BEATS    = 517;

    typedef enum int {
        PH_FREE,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH,
        PH_HOLD
    } phase_t;

    typedef struct {
        usbctl_pkg::in_item_t  item;
        bit                    typed;
        usbctl_pkg::out_item_t want;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // [0] req_dir_in, [16:1] req_length, [32:17] avail_len, [33] ep_dir_in,
    // [40:34] xferred, [41] app_ok, [47:42] zero
    logic [usbctl_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] cmd
    logic [1:0]                         s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // [0] out_dir_in, [7:1] packet_len, [23:8] packet_offset,
    // [39:24] copy_offset
    logic [usbctl_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // [2:0] action
    logic [2:0]                         m_axis_tuser;

    // Local copy of the transfer state, advanced on every accepted beat.
    logic        ctl_dir_in;
    logic [15:0] ctl_setup_len;
    logic [15:0] ctl_data_len;
    logic [15:0] ctl_total;

    usbctl_pkg::out_item_t pending_results[$];
    stim_row_t             directed_rows[$];

    phase_t      phase = PH_FREE;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_done = 1'b0;
    int          err_count = 0;
    int          beats_sent = 0;
    int          results_seen = 0;
    int          cycle_cnt = 0;
    int          stall_beats = 0;
    int          error_beats = 0;

    usb_control_transfer_stager_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run: a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("usb_control_transfer_stager_unit regression: fail");
            $finish;
        end
    end

    // Queue the next data packet from what is left of the data stage; the
    // remaining length clamps at zero once the total runs past it.
    function automatic usbctl_pkg::out_item_t next_packet(input logic [15:0] coff);
        usbctl_pkg::out_item_t r;
        logic [15:0]           rem;
        r   = '0;
        rem = (ctl_data_len > ctl_total) ? ctl_data_len - ctl_total : 16'd0;
        r.action        = usbctl_pkg::ACT_DATA;
        r.out_dir_in    = ctl_dir_in;
        r.packet_len    = (rem < PKT_MAX) ? rem[6:0] : 7'(PKT_MAX);
        r.packet_offset = ctl_total;
        r.copy_offset   = coff;
        return r;
    endfunction

    // Advance the transfer state by one command beat and return the beat the
    // block must produce for it.
    function automatic usbctl_pkg::out_item_t stage_predict(
        input usbctl_pkg::in_item_t it);
        usbctl_pkg::out_item_t r;
        logic [16:0]           sum;
        logic [15:0]           coff;
        r = '0;
        case (it.cmd)
            usbctl_pkg::CMD_RESET:
            begin
                ctl_dir_in    = 1'b0;
                ctl_setup_len = '0;
                ctl_data_len  = '0;
                ctl_total     = '0;
                r.action      = usbctl_pkg::ACT_NONE;
            end
            usbctl_pkg::CMD_START_DATA:
            begin
                ctl_dir_in    = it.req_dir_in;
                ctl_setup_len = it.req_length;
                ctl_total     = '0;
                ctl_data_len  = (it.avail_len < it.req_length) ? it.avail_len
                                                               : it.req_length;
                if (ctl_data_len != 0)
                    r = next_packet(16'd0);
                else
                begin
                    r.action     = usbctl_pkg::ACT_STATUS;
                    r.out_dir_in = ~ctl_dir_in;
                end
            end
            usbctl_pkg::CMD_START_STATUS:
            begin
                ctl_dir_in    = it.req_dir_in;
                ctl_setup_len = it.req_length;
                ctl_total     = '0;
                ctl_data_len  = '0;
                r.action      = usbctl_pkg::ACT_STATUS;
                r.out_dir_in  = ~ctl_dir_in;
            end
            default:
            begin
                if (it.ep_dir_in != ctl_dir_in)
                begin
                    // Status stage completion: any payload is an error.
                    r.action = (it.xferred == 0) ? usbctl_pkg::ACT_NONE
                                                 : usbctl_pkg::ACT_ERROR;
                end
                else
                begin
                    coff      = ctl_dir_in ? 16'd0 : ctl_total;
                    sum       = 17'(ctl_total) + 17'(it.xferred);
                    ctl_total = sum[16] ? 16'hFFFF : sum[15:0];
                    if (ctl_setup_len == ctl_total || it.xferred < PKT_MAX)
                    begin
                        if (it.app_ok)
                        begin
                            r.action     = usbctl_pkg::ACT_STATUS;
                            r.out_dir_in = ~ctl_dir_in;
                        end
                        else
                            r.action = usbctl_pkg::ACT_STALL;
                        r.copy_offset = coff;
                    end
                    else
                        r = next_packet(coff);
                end
            end
        endcase
        return r;
    endfunction

    function automatic usbctl_pkg::in_item_t mk_in(input usbctl_pkg::cmd_t c,
                                                   input logic rdir,
                                                   input logic [15:0] rlen,
                                                   input logic [15:0] avail,
                                                   input logic edir,
                                                   input logic [6:0] xfer,
                                                   input logic ok);
        usbctl_pkg::in_item_t it;
        it.cmd        = c;
        it.req_dir_in = rdir;
        it.req_length = rlen;
        it.avail_len  = avail;
        it.ep_dir_in  = edir;
        it.xferred    = xfer;
        it.app_ok     = ok;
        return it;
    endfunction

    function automatic usbctl_pkg::out_item_t mk_res(input usbctl_pkg::action_t a,
                                                     input logic odir,
                                                     input logic [6:0] plen,
                                                     input logic [15:0] poff,
                                                     input logic [15:0] coff);
        usbctl_pkg::out_item_t r;
        r.action        = a;
        r.out_dir_in    = odir;
        r.packet_len    = plen;
        r.packet_offset = poff;
        r.copy_offset   = coff;
        return r;
    endfunction

    function automatic void add_row(input usbctl_pkg::in_item_t it, input bit typed,
                                    input usbctl_pkg::out_item_t want);
        stim_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Mostly short lengths so transfers finish in a few packets; now and
    // then a full-range or all-ones value.
    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 260));
        endcase
    endfunction

    // Fill every field at random; fields a command ignores stay random too.
    function automatic usbctl_pkg::in_item_t rand_item();
        return mk_in(usbctl_pkg::cmd_t'($urandom_range(0, 3)), 1'($urandom),
                     16'($urandom), 16'($urandom), 1'($urandom),
                     7'($urandom_range(0, PKT_MAX)), 1'($urandom));
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    // Offer one beat and hold it until the block takes it; predict at the
    // accepting edge. Lower tvalid only when a gap is drawn, so a beat that
    // follows straight on keeps tvalid high across the edge.
    task automatic send_beat(input usbctl_pkg::in_item_t it, input bit typed,
                             input usbctl_pkg::out_item_t want,
                             output usbctl_pkg::out_item_t pred);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {6'b0, it.app_ok, it.xferred, it.ep_dir_in,
                          it.avail_len, it.req_length, it.req_dir_in};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = stage_predict(it);
        pending_results.push_back(typed ? want : pred);
        beats_sent++;
    endtask

    // One control transfer with random content: mostly a data stage that the
    // host completes packet by packet, followed by the status stage; the
    // rest status-only transfers and loose noise beats.
    task automatic run_transfer();
        usbctl_pkg::in_item_t  it;
        usbctl_pkg::out_item_t res;
        int                    steps;
        int                    kind;
        kind = $urandom_range(0, 19);
        it   = rand_item();
        if (kind < 3)
        begin
            send_beat(it, 1'b0, '0, res);
            return;
        end
        if (kind < 6)
        begin
            it.cmd        = usbctl_pkg::CMD_START_STATUS;
            it.req_length = pick_len();
            send_beat(it, 1'b0, '0, res);
        end
        else
        begin
            it.cmd        = usbctl_pkg::CMD_START_DATA;
            it.req_length = pick_len();
            it.avail_len  = $urandom_range(0, 1) ? 16'hFFFF : pick_len();
            send_beat(it, 1'b0, '0, res);
            steps = $urandom_range(1, 10);
            while (res.action == usbctl_pkg::ACT_DATA && steps > 0)
            begin
                it           = rand_item();
                it.cmd       = usbctl_pkg::CMD_COMPLETE;
                it.ep_dir_in = ctl_dir_in;
                it.xferred   = res.packet_len;
                it.app_ok    = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) == 0)
                    it.xferred = 7'($urandom_range(0, PKT_MAX));
                if ($urandom_range(0, 14) == 0)
                    it.ep_dir_in = ~ctl_dir_in;
                send_beat(it, 1'b0, '0, res);
                steps--;
            end
        end
        // Close with the status stage completion when one was queued.
        if (res.action == usbctl_pkg::ACT_STATUS)
        begin
            it           = rand_item();
            it.cmd       = usbctl_pkg::CMD_COMPLETE;
            it.ep_dir_in = res.out_dir_in;
            it.xferred   = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(1, PKT_MAX))
                                                       : 7'd0;
            send_beat(it, 1'b0, '0, res);
        end
    endtask

    task automatic run_phase(input phase_t ph, input int tx_pct, input int rx_pct,
                             input int beats);
        int stop_at;
        phase        = ph;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at      = beats_sent + beats;
        while (beats_sent < stop_at)
            run_transfer();
    endtask

    // Receiver: random stalls at the current rate; in the hold phase, refuse
    // every beat for a fixed stretch so the pipeline backs up into the input.
    initial
    begin : rx_side
        int hold_cnt;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_HOLD && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        usbctl_pkg::out_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected beat, action", m_axis_tuser, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.action)
                    flag_mismatch("action", m_axis_tuser, want.action);
                else if (m_axis_tuser == usbctl_pkg::ACT_STALL)
                    stall_beats++;
                else if (m_axis_tuser == usbctl_pkg::ACT_ERROR)
                    error_beats++;
                if (m_axis_tdata[0] !== want.out_dir_in)
                    flag_mismatch("out_dir_in", m_axis_tdata[0], want.out_dir_in);
                if (m_axis_tdata[7:1] !== want.packet_len)
                    flag_mismatch("packet_len", m_axis_tdata[7:1], want.packet_len);
                if (m_axis_tdata[23:8] !== want.packet_offset)
                    flag_mismatch("packet_offset", m_axis_tdata[23:8],
                                  want.packet_offset);
                if (m_axis_tdata[39:24] !== want.copy_offset)
                    flag_mismatch("copy_offset", m_axis_tdata[39:24],
                                  want.copy_offset);
            end
            results_seen++;
        end
    end

    initial
    begin : stimulus
        usbctl_pkg::out_item_t res;
        usbctl_pkg::in_item_t  it;
        ctl_dir_in    = 1'b0;
        ctl_setup_len = '0;
        ctl_data_len  = '0;
        ctl_total     = '0;

        // Completion right after reset: an OUT request of wLength 0, so the
        // zero-byte packet ends the data stage at once.
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 0, 0, 1), 1,
                mk_res(usbctl_pkg::ACT_STATUS, 1, 0, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_RESET, 1, 16'hFFFF, 16'hFFFF, 1, 64, 1), 1,
                mk_res(usbctl_pkg::ACT_NONE, 0, 0, 0, 0));
        // Largest IN transfer, then a full packet, an empty status completion and a stray status payload.
        add_row(mk_in(usbctl_pkg::CMD_START_DATA, 1, 16'hFFFF, 16'hFFFF, 0, 0, 0), 1,
                mk_res(usbctl_pkg::ACT_DATA, 1, 64, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 1, 64, 1), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 1, 0, 0, 0, 0, 1), 1,
                mk_res(usbctl_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 1, 0, 0, 0, 64, 1), 1,
                mk_res(usbctl_pkg::ACT_ERROR, 0, 0, 0, 0));
        // Short packet with the application refusing: stall.
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 1, 63, 0), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_START_STATUS, 0, 0, 16'hFFFF, 1, 0, 0), 1,
                mk_res(usbctl_pkg::ACT_STATUS, 1, 0, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_START_STATUS, 1, 16'hFFFF, 0, 0, 0, 0), 1,
                mk_res(usbctl_pkg::ACT_STATUS, 0, 0, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 1, 0, 1), 0, '0);
        // OUT transfer ending exactly on wLength, with copy offsets.
        add_row(mk_in(usbctl_pkg::CMD_START_DATA, 0, 100, 16'hFFFF, 0, 0, 0), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 0, 64, 1), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 0, 36, 1), 0, '0);
        // Nothing offered: straight to status.
        add_row(mk_in(usbctl_pkg::CMD_START_DATA, 1, 10, 0, 0, 0, 0), 1,
                mk_res(usbctl_pkg::ACT_STATUS, 0, 0, 0, 0));
        // Total reaching or passing the data length gives a zero-length data packet.
        add_row(mk_in(usbctl_pkg::CMD_START_DATA, 1, 200, 64, 0, 0, 0), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 1, 64, 1), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 1, 0, 1), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_START_DATA, 0, 16'hFFFF, 1, 0, 0, 0), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 0, 1, 0), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 1, 1, 1), 1,
                mk_res(usbctl_pkg::ACT_ERROR, 0, 0, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_START_DATA, 0, 0, 16'hFFFF, 0, 0, 0), 1,
                mk_res(usbctl_pkg::ACT_STATUS, 1, 0, 0, 0));
        add_row(mk_in(usbctl_pkg::CMD_COMPLETE, 0, 0, 0, 0, 64, 1), 0, '0);
        add_row(mk_in(usbctl_pkg::CMD_RESET, 0, 0, 0, 0, 0, 0), 1,
                mk_res(usbctl_pkg::ACT_NONE, 0, 0, 0, 0));

        // Hold reset, then release it on a rising edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct  = 19;
        rx_stall_pct = 19;
        foreach (directed_rows[i])
            send_beat(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].want, res);

        // Saturate the running total: a maximum-length OUT transfer fed with
        // oversized all-ones byte counts until the total pins at all ones.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_beat(mk_in(usbctl_pkg::CMD_START_DATA, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0),
                  1'b0, '0, res);
        repeat (SAT_BEATS)
        begin
            it = rand_item();
            it.cmd       = usbctl_pkg::CMD_COMPLETE;
            it.ep_dir_in = 1'b0;
            it.xferred   = 7'h7F;
            it.app_ok    = 1'b1;
            send_beat(it, 1'b0, '0, res);
        end

        run_phase(PH_FREE, 0, 0, PHASE_BEATS);
        run_phase(PH_TX_IDLE, 67, 0, PHASE_BEATS);
        run_phase(PH_RX_STALL, 0, 67, PHASE_BEATS);
        run_phase(PH_BOTH, 19, 19, PHASE_BEATS);
        // Keep offering beats while the receiver holds off.
        run_phase(PH_HOLD, 0, 0, HOLD_BEATS);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d command beats incl. total saturation and a %0d-cycle hold",
                 beats_sent, HOLD_CYCLES);
        $display("checked %0d result beats (%0d stalls, %0d status errors)",
                 results_seen, stall_beats, error_beats);
        if (err_count == 0)
            $display("usb_control_transfer_stager_unit regression: pass");
        else
            $display("usb_control_transfer_stager_unit regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/usbctl_pkg.sv
rtl/core/usb_control_transfer_stager_unit.sv
test/usb_control_transfer_stager_unit_tb.sv
